>>> hw/rtl/ps2me_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; every module of the block imports this package.
package ps2me_pkg;

	localparam int unsigned SIZE_W  = 13;
	localparam int unsigned COORD_W = 12;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [SIZE_W-1:0] SCREEN_MAX   = 13'd4096;
	localparam logic [COORD_W-1:0] CURSOR_X_RESET = 12'd320;
	localparam logic [COORD_W-1:0] CURSOR_Y_RESET = 12'd240;

	localparam logic [7:0] HEADER_MARK = 8'h08;
	localparam logic [2:0] BUTTON_MASK = 3'h7;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Event codes.
	localparam logic [1:0] EV_MOVE  = 2'd0;
	localparam logic [1:0] EV_DOWN  = 2'd1;
	localparam logic [1:0] EV_UP    = 2'd2;
	localparam logic [1:0] EV_CLICK = 2'd3;

	// One completed packet, handed from the front part to the back part.
	typedef struct packed {
		logic [COORD_W-1:0] cursor_x;
		logic [COORD_W-1:0] cursor_y;
		logic [2:0]         buttons;
		logic [2:0]         changed;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] cursor_x;
		logic [COORD_W-1:0] cursor_y;
		logic [1:0]         button;
		logic               last;
	} event_t;

	// Clamp signed cursor+delta to 0..size-1, size held to 1..4096.
	function automatic logic [COORD_W-1:0] clamp_coord(logic signed [13:0] v,
			logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] eff;
		logic [SIZE_W-1:0] limit;
		logic [COORD_W-1:0] res;
		eff = size;
		if (eff == '0) begin
			eff = 13'd1;
		end else if (eff > SCREEN_MAX) begin
			eff = SCREEN_MAX;
		end
		limit = eff - 13'd1;
		if (v < 0) begin
			res = '0;
		end else if (v[12:0] > limit) begin
			res = limit[COORD_W-1:0];
		end else begin
			res = v[COORD_W-1:0];
		end
		return res;
	endfunction

endpackage

>>> hw/rtl/ps2_mouse_packet_to_events.sv
// PS/2 mouse packet decoder. Raw mouse bytes are pushed one per cycle while
// full is low; every third byte of a packet (the header must carry bit 3)
// moves the clamped cursor and yields one move event plus a down, or an up
// and a click, per changed button, at most seven events with the last one
// marked. A byte is taken whenever the two-entry command queue has room; the
// event stage delivers one event per cycle while its output is empty or popped.
// Uses ps2me_pkg, ps2me_front, ps2me_cmd_fifo and ps2me_back.
module ps2_mouse_packet_to_events import ps2me_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [SIZE_W-1:0]  cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         event_kind,
	output logic [COORD_W-1:0] cursor_x_out,
	output logic [COORD_W-1:0] cursor_y_out,
	output logic [1:0]         button_index,
	output logic               last_event
);

	logic   byte_valid;
	logic   front_valid;
	cmd_t   front_cmd;
	logic   head_valid;
	cmd_t   head_cmd;
	logic   head_done;
	logic   ev_valid;
	event_t ev;

	assign byte_valid = push && !full;

	ps2me_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.byte_valid (byte_valid),
		.rx_byte    (rx_byte),
		.cmd_valid  (front_valid),
		.cmd        (front_cmd)
	);

	ps2me_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (front_valid),
		.wr_data  (front_cmd),
		.full     (full),
		.rd_en    (head_done),
		.rd_valid (head_valid),
		.rd_data  (head_cmd)
	);

	ps2me_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_done  (head_done),
		.ev_valid  (ev_valid),
		.ev        (ev),
		.ev_pop    (pop)
	);

	assign empty        = !ev_valid;
	assign event_kind   = ev.kind;
	assign cursor_x_out = ev.cursor_x;
	assign cursor_y_out = ev.cursor_y;
	assign button_index = ev.button;
	assign last_event   = ev.last;

endmodule

>>> hw/rtl/ps2me_front.sv
// Front part: holds the screen size registers, assembles 3-byte packets,
// updates the clamped cursor and issues one command per packet. Uses ps2me_pkg.
module ps2me_front import ps2me_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [SIZE_W-1:0] cfg_wdata,
	input  logic              byte_valid,
	input  logic [7:0]        rx_byte,
	output logic              cmd_valid,
	output cmd_t              cmd
);

	typedef enum logic [2:0] {
		WAIT_HDR = 3'b001,
		WAIT_X   = 3'b010,
		WAIT_Y   = 3'b100
	} pos_t;

	pos_t               pos_q;
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [7:0]         header_q;
	logic [7:0]         xmot_q;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;
	logic [2:0]         prev_btn_q;

	logic signed [13:0] nx;
	logic signed [13:0] ny;
	logic [COORD_W-1:0] cx_new;
	logic [COORD_W-1:0] cy_new;
	logic               complete;

	assign nx = $signed({2'b00, cx_q}) + 14'(signed'(xmot_q));
	assign ny = $signed({2'b00, cy_q}) - 14'(signed'(rx_byte));
	assign cx_new = clamp_coord(nx, width_q);
	assign cy_new = clamp_coord(ny, height_q);
	assign complete = byte_valid && (pos_q == WAIT_Y);

	assign cmd_valid     = complete;
	assign cmd.cursor_x  = cx_new;
	assign cmd.cursor_y  = cy_new;
	assign cmd.buttons   = header_q[2:0] & BUTTON_MASK;
	assign cmd.changed   = (header_q[2:0] & BUTTON_MASK) ^ prev_btn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WIDTH:  width_q  <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= WAIT_HDR;
			header_q   <= '0;
			xmot_q     <= '0;
			cx_q       <= CURSOR_X_RESET;
			cy_q       <= CURSOR_Y_RESET;
			prev_btn_q <= '0;
		end else if (byte_valid) begin
			unique case (pos_q)
				WAIT_HDR: begin
					// A byte without the header mark cannot start a packet.
					if ((rx_byte & HEADER_MARK) != '0) begin
						header_q <= rx_byte;
						pos_q    <= WAIT_X;
					end
				end
				WAIT_X: begin
					xmot_q <= rx_byte;
					pos_q  <= WAIT_Y;
				end
				WAIT_Y: begin
					cx_q       <= cx_new;
					cy_q       <= cy_new;
					prev_btn_q <= header_q[2:0] & BUTTON_MASK;
					pos_q      <= WAIT_HDR;
				end
				default: pos_q <= WAIT_HDR;
			endcase
		end
	end

endmodule

>>> hw/rtl/ps2me_cmd_fifo.sv
// Two-entry command queue between the front and back parts.
// Uses cmd_t from ps2me_pkg.
module ps2me_cmd_fifo import ps2me_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output logic rd_valid,
	output cmd_t rd_data
);

	cmd_t       mem [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> hw/rtl/ps2me_back.sv
// Back part: expands one packet command into its move and button events, one
// per cycle into an output register while it is empty or popped. Uses ps2me_pkg.
module ps2me_back import ps2me_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	input  cmd_t   cmd,
	output logic   cmd_done,
	output logic   ev_valid,
	output event_t ev,
	input  logic   ev_pop
);

	logic       moved_q;
	logic       click_q;
	logic [1:0] cbtn_q;
	logic [2:0] rem_q;
	logic       out_valid_q;
	event_t     out_q;

	logic       emit;
	event_t     ev_next;
	logic [1:0] low_idx;
	logic [2:0] rem_clr;

	// Lowest changed button still to be reported.
	always_comb begin
		low_idx = 2'd0;
		rem_clr = rem_q;
		priority if (rem_q[0]) begin
			low_idx = 2'd0;
			rem_clr = rem_q & 3'b110;
		end else if (rem_q[1]) begin
			low_idx = 2'd1;
			rem_clr = rem_q & 3'b101;
		end else if (rem_q[2]) begin
			low_idx = 2'd2;
			rem_clr = rem_q & 3'b011;
		end else begin
			low_idx = 2'd0;
			rem_clr = rem_q;
		end
	end

	always_comb begin
		ev_next.cursor_x = cmd.cursor_x;
		ev_next.cursor_y = cmd.cursor_y;
		priority if (!moved_q) begin
			ev_next.kind   = EV_MOVE;
			ev_next.button = 2'd0;
			ev_next.last   = (cmd.changed == '0);
		end else if (click_q) begin
			ev_next.kind   = EV_CLICK;
			ev_next.button = cbtn_q;
			ev_next.last   = (rem_q == '0);
		end else if (cmd.buttons[low_idx]) begin
			ev_next.kind   = EV_DOWN;
			ev_next.button = low_idx;
			ev_next.last   = (rem_clr == '0);
		end else begin
			// A release is always followed by its click.
			ev_next.kind   = EV_UP;
			ev_next.button = low_idx;
			ev_next.last   = 1'b0;
		end
	end

	assign emit     = cmd_valid && (!out_valid_q || ev_pop);
	assign cmd_done = emit && ev_next.last;
	assign ev_valid = out_valid_q;
	assign ev       = out_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= ev_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moved_q     <= 1'b0;
			click_q     <= 1'b0;
			cbtn_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (ev_pop) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				if (ev_next.last) begin
					moved_q <= 1'b0;
					click_q <= 1'b0;
					rem_q   <= '0;
				end else if (!moved_q) begin
					moved_q <= 1'b1;
					rem_q   <= cmd.changed;
				end else if (click_q) begin
					click_q <= 1'b0;
				end else begin
					rem_q <= rem_clr;
					if (ev_next.kind == EV_UP) begin
						click_q <= 1'b1;
						cbtn_q  <= low_idx;
					end
				end
			end
		end
	end

endmodule

>>> test/ps2me_checker.sv
// Checker for the PS/2 mouse packet decoder: watches the byte, event and register ports,
// predicts the event stream and compares each popped event against it.
// Depends on ps2me_pkg for widths, event codes and the event struct.
module ps2me_checker import ps2me_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [SIZE_W-1:0]  cfg_wdata,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               empty,
	input  logic               pop,
	input  logic [1:0]         event_kind,
	input  logic [COORD_W-1:0] cursor_x_out,
	input  logic [COORD_W-1:0] cursor_y_out,
	input  logic [1:0]         button_index,
	input  logic               last_event,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BUTTONS = 3;

	logic [1:0]         pkt_pos;
	logic [7:0]         hdr_byte;
	logic [7:0]         dx_byte;
	logic [COORD_W-1:0] cur_x;
	logic [COORD_W-1:0] cur_y;
	logic [2:0]         held_buttons;
	logic [SIZE_W-1:0]  scr_w;
	logic [SIZE_W-1:0]  scr_h;
	event_t             expected_events[$];

	task automatic report(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		errors++;
	endtask

	function automatic string describe(input event_t e);
		return $sformatf("kind %0d x %0d y %0d button %0d last %0d",
			e.kind, e.cursor_x, e.cursor_y, e.button, e.last);
	endfunction

	// A size of zero behaves as one and anything past the maximum as the maximum.
	function automatic logic [COORD_W-1:0] bound_coord(input int pos,
			input logic [SIZE_W-1:0] size);
		int span;
		span = (size == '0) ? 1 : ((size > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(size));
		if (pos < 0) begin
			return '0;
		end
		if (pos >= span) begin
			return COORD_W'(span - 1);
		end
		return COORD_W'(pos);
	endfunction

	task automatic add_event(input logic [1:0] kind, input logic [1:0] button);
		event_t e;
		e.kind     = kind;
		e.cursor_x = cur_x;
		e.cursor_y = cur_y;
		e.button   = button;
		e.last     = 1'b0;
		expected_events.push_back(e);
	endtask

	task automatic take_byte(input logic [7:0] b);
		int nx;
		int ny;
		logic [2:0] now_btn;
		if (pkt_pos == 2'd0) begin
			// Headers without the marker bit are thrown away.
			if ((b & HEADER_MARK) != 8'h00) begin
				hdr_byte = b;
				pkt_pos  = 2'd1;
			end
		end else if (pkt_pos == 2'd1) begin
			dx_byte = b;
			pkt_pos = 2'd2;
		end else begin
			pkt_pos = 2'd0;
			nx = int'(cur_x) + int'($signed(dx_byte));
			ny = int'(cur_y) - int'($signed(b));
			cur_x = bound_coord(nx, scr_w);
			cur_y = bound_coord(ny, scr_h);
			now_btn = hdr_byte[2:0] & BUTTON_MASK;
			add_event(EV_MOVE, 2'd0);
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (!held_buttons[i] && now_btn[i]) begin
					add_event(EV_DOWN, 2'(i));
				end else if (held_buttons[i] && !now_btn[i]) begin
					add_event(EV_UP, 2'(i));
					add_event(EV_CLICK, 2'(i));
				end
			end
			held_buttons = now_btn;
			expected_events[expected_events.size() - 1].last = 1'b1;
		end
	endtask

	task automatic take_event();
		event_t got;
		event_t want;
		got = {event_kind, cursor_x_out, cursor_y_out, button_index, last_event};
		if (expected_events.size() == 0) begin
			report({"event with nothing expected: ", describe(got)});
		end else begin
			want = expected_events.pop_front();
			if (got !== want) begin
				report({"got ", describe(got), ", expected ", describe(want)});
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_pos      = 2'd0;
			hdr_byte     = 8'h00;
			dx_byte      = 8'h00;
			cur_x        = CURSOR_X_RESET;
			cur_y        = CURSOR_Y_RESET;
			held_buttons = 3'b000;
			scr_w        = WIDTH_RESET;
			scr_h        = HEIGHT_RESET;
			expected_events.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_WIDTH) begin
					scr_w = cfg_wdata;
				end else begin
					scr_h = cfg_wdata;
				end
			end
			// Events leave only after their byte has passed the command queue and the output register, so pops come first.
			if (pop && !empty) begin
				take_event();
			end
			if (push && !full) begin
				take_byte(rx_byte);
			end
		end
		pending <= expected_events.size();
	end

endmodule

>>> test/tb_ps2_mouse_packet_to_events.sv
// Top of the PS/2 mouse decoder testbench: clock, reset, byte and register stimulus,
// random pop stalls, a watchdog and the verdict. Depends on ps2me_pkg, ps2me_checker
// and the block ps2_mouse_packet_to_events.
module tb_ps2_mouse_packet_to_events import ps2me_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_BYTES = 16;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_addr;
	logic [SIZE_W-1:0]  cfg_wdata;
	logic               push;
	logic               full;
	logic [7:0]         rx_byte;
	logic               empty;
	logic               pop;
	logic [1:0]         event_kind;
	logic [COORD_W-1:0] cursor_x_out;
	logic [COORD_W-1:0] cursor_y_out;
	logic [1:0]         button_index;
	logic               last_event;
	int                 errors;
	int                 pending;
	int                 send_idle_pct = 0;
	int                 recv_stall_pct = 0;
	int                 quiet_cycles;

	ps2_mouse_packet_to_events u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.event_kind   (event_kind),
		.cursor_x_out (cursor_x_out),
		.cursor_y_out (cursor_y_out),
		.button_index (button_index),
		.last_event   (last_event)
	);

	ps2me_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.event_kind   (event_kind),
		.cursor_x_out (cursor_x_out),
		.cursor_y_out (cursor_y_out),
		.button_index (button_index),
		.last_event   (last_event),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Ends the run if no transaction happens on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push    <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
	endtask

	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
			input logic [7:0] dy);
		send_byte(hdr);
		send_byte(dx);
		send_byte(dy);
	endtask

	// Holds the sender until every predicted event has been popped, then lets
	// the pipeline run dry.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_addr  <= REG_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_addr  <= REG_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Motion bytes lean toward the extremes so that clamping is hit often.
	function automatic logic [7:0] pick_motion();
		case ($urandom_range(7))
			0: return 8'h7F;
			1: return 8'h80;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	initial begin
		int sent;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
		arst_n    = 1'b0;
		push      = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = REG_WIDTH;
		cfg_wdata = '0;
		rx_byte   = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Headers without the marker bit are dropped.
		send_byte(8'h00);
		send_byte(8'hF7);
		send_packet(8'h08, 8'h7F, 8'h80);
		// Flag bits set in the header, all buttons pressed, y runs into the bottom.
		send_packet(8'hFF, 8'h7F, 8'h80);
		// All three released: the longest burst of events, x runs into the right edge.
		send_packet(8'h08, 8'h7F, 8'h7F);
		send_packet(8'h09, 8'h80, 8'h7F);
		send_packet(8'h0E, 8'h80, 8'h7F);
		// Ends at the top edge with right and middle released.
		send_packet(8'hC8, 8'h80, 8'h7F);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  w = 13'd0;    h = 13'd8191; end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  w = 13'd4096; h = 13'd4096; end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; w = 13'd1;    h = 13'd4097; end
				3: begin send_idle_pct = 22; recv_stall_pct = 22; w = 13'd23;   h = 13'd11;   end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					w = WIDTH_RESET;
					h = 13'($urandom_range(1, 4096));
				end
			endcase
			write_screen(w, h);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				if ($urandom_range(99) < 12) begin
					// A stray byte; it may be dropped or knock the packet framing off.
					send_byte(8'($urandom_range(255)));
				end else begin
					send_packet(8'($urandom_range(255)) | HEADER_MARK, pick_motion(),
						pick_motion());
					sent += 3;
				end
			end
			settle();
		end

		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ps2me_pkg.sv
hw/rtl/ps2me_front.sv
hw/rtl/ps2me_cmd_fifo.sv
hw/rtl/ps2me_back.sv
hw/rtl/ps2_mouse_packet_to_events.sv
test/ps2me_checker.sv
test/tb_ps2_mouse_packet_to_events.sv
